/* hw/rtl/sacnf_pkg.sv */
// Shared constants, register indexes and types for the sACN packet framer.
// No dependencies; every other file of the block depends on this package.
package sacnf_pkg;

  // Channel and packet geometry
  localparam int MAX_CHANNELS = 4096;
  localparam int POS_W        = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = 13;
  localparam int PKT_CHANNELS = 512;
  localparam int PKT_SHIFT    = $clog2(PKT_CHANNELS);
  localparam int PKT_N_W      = PKT_SHIFT + 1;

  // Payload widths
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 64;
  localparam int VB_W    = 4;
  localparam int UNI_W   = 16;
  localparam int SEQ_W   = 8;

  // Header: 126 bytes = 15 full words plus six bytes that open the packer
  localparam int HDR_FULL_WORDS = 15;
  localparam int HDR_IDX_W      = 4;
  localparam int HDR_TAIL_W     = 48;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNIVERSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CID_HIGH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CID_LOW        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_A         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_B         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_C         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_D         = 3'd7;

  // Identity memory: CID and source name words, entry = register index - 2
  localparam int ID_DEPTH  = 6;
  localparam int ID_ADDR_W = $clog2(ID_DEPTH);

  localparam logic [ID_ADDR_W-1:0] ID_CID_HIGH = 3'd0;
  localparam logic [ID_ADDR_W-1:0] ID_CID_LOW  = 3'd1;
  localparam logic [ID_ADDR_W-1:0] ID_NAME_A   = 3'd2;
  localparam logic [ID_ADDR_W-1:0] ID_NAME_B   = 3'd3;
  localparam logic [ID_ADDR_W-1:0] ID_NAME_C   = 3'd4;
  localparam logic [ID_ADDR_W-1:0] ID_NAME_D   = 3'd5;

  // Per-packet header context
  typedef struct packed {
    logic [PKT_N_W-1:0] n;
    logic [UNI_W-1:0]   universe;
    logic [SEQ_W-1:0]   sequence_no;
  } hdr_ctx_t;

  // Two read ports of the identity memory
  typedef struct packed {
    logic [ID_ADDR_W-1:0] addr_a;
    logic [ID_ADDR_W-1:0] addr_b;
  } id_rd_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_a;
    logic [WORD_W-1:0] data_b;
  } id_rd_rsp_t;

endpackage

/* hw/rtl/sacnf_in_if.sv */
// Input channel of the sACN framer: one channel byte per beat.
// Depends on sacnf_pkg for the payload width.
interface sacnf_in_if;
  logic                         valid;
  logic                         ready;
  logic [sacnf_pkg::BYTE_W-1:0] channel_byte;

  modport source (output valid, output channel_byte, input ready);
  modport sink   (input valid, input channel_byte, output ready);
endinterface

/* hw/rtl/sacnf_out_if.sv */
// Result channel of the sACN framer: one packet word per beat.
// Depends on sacnf_pkg for the payload widths.
interface sacnf_out_if;
  logic                         valid;
  logic                         ready;
  logic [sacnf_pkg::WORD_W-1:0] packet_word;
  logic [sacnf_pkg::VB_W-1:0]   valid_bytes;
  logic                         packet_end;
  logic                         run_last;

  modport source (output valid, output packet_word, output valid_bytes,
                  output packet_end, output run_last, input ready);
  modport sink   (input valid, input packet_word, input valid_bytes,
                  input packet_end, input run_last, output ready);
endinterface

/* hw/rtl/sacnf_id_mem.sv */
// Identity memory: CID and source name words, written by the config port.
// Two registered read ports; entries never written read as zero.
// Depends on sacnf_pkg.
module sacnf_id_mem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sacnf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacnf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  sacnf_pkg::id_rd_req_t           rd_req,
  output sacnf_pkg::id_rd_rsp_t           rd_rsp
);
  import sacnf_pkg::*;

  logic [WORD_W-1:0]    mem_r [ID_DEPTH];
  logic [ID_DEPTH-1:0]  vld_r;
  logic [ID_DEPTH-1:0]  vld_nxt;
  logic [WORD_W-1:0]    rd_a_r;
  logic [WORD_W-1:0]    rd_b_r;
  logic                 rd_a_vld_r;
  logic                 rd_b_vld_r;
  logic                 wr_en;
  logic [ID_ADDR_W-1:0] wr_addr;

  // Registers from the CID on land in the memory
  assign wr_en   = cfg_we && (cfg_index >= CFG_CID_HIGH);
  assign wr_addr = ID_ADDR_W'(cfg_index - CFG_CID_HIGH);

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd_a_vld_r <= 1'b0;
      rd_b_vld_r <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      rd_a_vld_r <= vld_r[rd_req.addr_a];
      rd_b_vld_r <= vld_r[rd_req.addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= cfg_data;
    end
    rd_a_r <= mem_r[rd_req.addr_a];
    rd_b_r <= mem_r[rd_req.addr_b];
  end

  assign rd_rsp.data_a = rd_a_vld_r ? rd_a_r : '0;
  assign rd_rsp.data_b = rd_b_vld_r ? rd_b_r : '0;

endmodule

/* hw/rtl/sacnf_hdr_gen.sv */
// Header word builder: maps a header word index to its identity memory
// reads and assembles the 64-bit word from constants, context and read data.
// Depends on sacnf_pkg.
module sacnf_hdr_gen (
  input  logic [sacnf_pkg::HDR_IDX_W-1:0]  rd_idx,
  input  logic [sacnf_pkg::HDR_IDX_W-1:0]  word_idx,
  input  sacnf_pkg::hdr_ctx_t             ctx,
  input  sacnf_pkg::id_rd_rsp_t           id_rsp,
  output sacnf_pkg::id_rd_req_t           id_req,
  output logic [sacnf_pkg::WORD_W-1:0]     hdr_word,
  output logic [sacnf_pkg::HDR_TAIL_W-1:0] hdr_tail
);
  import sacnf_pkg::*;

  logic [11:0] root_len;
  logic [11:0] frame_len;
  logic [11:0] dmp_len;
  logic [15:0] value_cnt;
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;

  // Lengths stay below 0x1000, so the 0x7 flags sit in the top nibble
  assign root_len  = 12'(ctx.n) + 12'd110;
  assign frame_len = 12'(ctx.n) + 12'd88;
  assign dmp_len   = 12'(ctx.n) + 12'd11;
  assign value_cnt = 16'(ctx.n) + 16'd1;

  assign a = id_rsp.data_a;
  assign b = id_rsp.data_b;

  // Read addresses for the word that will be built next cycle
  always_comb begin
    id_req.addr_a = ID_CID_HIGH;
    id_req.addr_b = ID_CID_LOW;
    case (rd_idx)
      4'd2, 4'd3: id_req.addr_a = ID_CID_HIGH;
      4'd4:       id_req.addr_a = ID_CID_LOW;
      4'd5, 4'd6: id_req.addr_a = ID_NAME_A;
      4'd7:       id_req.addr_a = ID_NAME_B;
      4'd8:       id_req.addr_a = ID_NAME_C;
      4'd9:       id_req.addr_a = ID_NAME_D;
      default:    id_req.addr_a = ID_CID_HIGH;
    endcase
    case (rd_idx)
      4'd3:    id_req.addr_b = ID_CID_LOW;
      4'd6:    id_req.addr_b = ID_NAME_B;
      4'd7:    id_req.addr_b = ID_NAME_C;
      4'd8:    id_req.addr_b = ID_NAME_D;
      default: id_req.addr_b = ID_CID_LOW;
    endcase
  end

  always_comb begin
    case (word_idx)
      4'd0:    hdr_word = 64'h0010_0000_4153_432d;
      4'd1:    hdr_word = 64'h4531_2e31_3700_0000;
      4'd2:    hdr_word = {4'h7, root_len, 32'h0000_0004, a[63:48]};
      4'd3:    hdr_word = {a[47:0], b[63:48]};
      4'd4:    hdr_word = {a[47:0], 4'h7, frame_len};
      4'd5:    hdr_word = {32'h0000_0002, a[63:32]};
      4'd6:    hdr_word = {a[31:0], b[63:32]};
      4'd7:    hdr_word = {a[31:0], b[63:32]};
      4'd8:    hdr_word = {a[31:0], b[63:32]};
      4'd9:    hdr_word = {a[31:0], 32'h0};
      4'd13:   hdr_word = {32'h0, 8'd100, 16'h0, ctx.sequence_no};
      4'd14:   hdr_word = {8'h00, ctx.universe, 4'h7, dmp_len, 8'h02, 8'ha1, 8'h00};
      default: hdr_word = '0;
    endcase
  end

  // First address low byte, increment, value count, start code
  assign hdr_tail = {8'h00, 16'h0001, value_cnt, 8'h00};

endmodule

/* hw/rtl/sacn_universe_packet_framer.sv */
// Top level of the sACN universe packet framer: control sequencer, packer
// and output register. Depends on sacnf_pkg, sacnf_in_if, sacnf_out_if,
// sacnf_id_mem and sacnf_hdr_gen.
//
// Channel bytes enter one per beat and leave inside E1.31 data packets of at
// most 512 channels, as big-endian 64-bit words with a count of valid leading
// bytes. A byte that continues a packet is accepted and placed in the frame,
// then packed (with at most one result beat); no new byte is taken until the
// pack step is done. A byte that opens a packet is accepted, then 15 header
// beats are shown one per cycle, unless the output channel stalls, through
// the output register, then the pack step folds the last six header bytes and
// the byte itself together. CID and source name live in a six-entry identity
// memory with two registered read ports, read one header word ahead; its
// entries carry valid bits that reset clears, so no clearing pass runs after
// reset. Write configuration only while the block is idle. channel_count
// values above 4096 act as 4096; zero drops every byte without a result.
module sacn_universe_packet_framer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sacnf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacnf_pkg::CFG_DATA_W-1:0] cfg_data,
  sacnf_in_if.sink                        in_chan,
  sacnf_out_if.source                     out_chan
);
  import sacnf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HDR  = 3'b010,
    ST_BYTE = 3'b100
  } state_t;

  // Configuration held in flops (used on every beat)
  logic [CNT_W-1:0] chan_count_r;
  logic [UNI_W-1:0] first_uni_r;

  // Control state
  state_t               state_r, state_nxt;
  logic [POS_W-1:0]     chan_pos_r, chan_pos_nxt;
  logic [SEQ_W-1:0]     seq_r, seq_nxt;
  logic [HDR_IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic [2:0]           pend_cnt_r, pend_cnt_nxt;
  logic                 is_end_r, is_end_nxt;

  // Payload held per item
  logic [55:0]          pend_bytes_r, pend_bytes_nxt;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  hdr_ctx_t             ctx_r, ctx_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    out_word_r, out_word_nxt;
  logic [VB_W-1:0]      out_vb_r, out_vb_nxt;
  logic                 out_end_r, out_end_nxt;
  logic                 out_last_r, out_last_nxt;

  // Frame position arithmetic at accept
  logic [CNT_W-1:0]     cnt_eff;
  logic [POS_W-1:0]     pos_cur;
  logic [CNT_W-1:0]     pos_p1;
  logic [CNT_W-1:0]     left;
  logic                 accept;
  logic                 slot_free;

  // Packer
  logic [WORD_W-1:0]    pack_v;
  logic [VB_W-1:0]      pack_cnt;
  logic [VB_W-1:0]      pack_sh;

  // Header builder and identity memory
  id_rd_req_t           id_req;
  id_rd_rsp_t           id_rsp;
  logic [WORD_W-1:0]    hdr_word;
  logic [HDR_TAIL_W-1:0] hdr_tail;

  sacnf_id_mem u_id_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_req    (id_req),
    .rd_rsp    (id_rsp)
  );

  // Read addresses follow the next word index so data lines up with hdr_idx_r
  sacnf_hdr_gen u_hdr_gen (
    .rd_idx   (hdr_idx_nxt),
    .word_idx (hdr_idx_r),
    .ctx      (ctx_r),
    .id_rsp   (id_rsp),
    .id_req   (id_req),
    .hdr_word (hdr_word),
    .hdr_tail (hdr_tail)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;

  // Clamp the count; restart the frame if the count shrank below the position
  assign cnt_eff = (chan_count_r > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                          : chan_count_r;
  assign pos_cur = ({1'b0, chan_pos_r} >= cnt_eff) ? '0 : chan_pos_r;
  assign pos_p1  = {1'b0, pos_cur} + CNT_W'(1);
  assign left    = cnt_eff - {1'b0, pos_cur};

  // Shift the byte into the pending word and left-align what is valid
  assign pack_v   = {pend_bytes_r, byte_r};
  assign pack_cnt = VB_W'(pend_cnt_r) + VB_W'(1);
  assign pack_sh  = VB_W'(8) - pack_cnt;

  always_comb begin
    state_nxt      = state_r;
    chan_pos_nxt   = chan_pos_r;
    seq_nxt        = seq_r;
    hdr_idx_nxt    = hdr_idx_r;
    pend_cnt_nxt   = pend_cnt_r;
    pend_bytes_nxt = pend_bytes_r;
    is_end_nxt     = is_end_r;
    byte_nxt       = byte_r;
    ctx_nxt        = ctx_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_word_nxt   = out_word_r;
    out_vb_nxt     = out_vb_r;
    out_end_nxt    = out_end_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        // Zero count: drop the byte, touch nothing
        if (accept && (cnt_eff != '0)) begin
          byte_nxt     = in_chan.channel_byte;
          chan_pos_nxt = (pos_p1 >= cnt_eff) ? '0 : pos_p1[POS_W-1:0];
          if (pos_cur == '0) begin
            seq_nxt = seq_r + SEQ_W'(1);
          end
          is_end_nxt = ({1'b0, pos_cur} == (cnt_eff - CNT_W'(1))) ||
                       (pos_cur[PKT_SHIFT-1:0] == {PKT_SHIFT{1'b1}});
          ctx_nxt.n  = (left >= CNT_W'(PKT_CHANNELS)) ? PKT_N_W'(PKT_CHANNELS)
                                                       : left[PKT_N_W-1:0];
          ctx_nxt.universe    = first_uni_r + UNI_W'(pos_cur[POS_W-1:PKT_SHIFT]);
          ctx_nxt.sequence_no = seq_nxt;
          if (pos_cur[PKT_SHIFT-1:0] == '0) begin
            hdr_idx_nxt = '0;
            state_nxt   = ST_HDR;
          end else begin
            state_nxt   = ST_BYTE;
          end
        end
      end

      ST_HDR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hdr_word;
          out_vb_nxt    = VB_W'(8);
          out_end_nxt   = 1'b0;
          // Last header beat closes the run unless the packet ends on this byte
          out_last_nxt  = (hdr_idx_r == HDR_IDX_W'(HDR_FULL_WORDS - 1)) && !is_end_r;
          if (hdr_idx_r == HDR_IDX_W'(HDR_FULL_WORDS - 1)) begin
            // Drop any stale bytes; load the six header bytes that remain
            pend_bytes_nxt = {8'h00, hdr_tail};
            pend_cnt_nxt   = 3'd6;
            state_nxt      = ST_BYTE;
          end else begin
            hdr_idx_nxt = hdr_idx_r + HDR_IDX_W'(1);
          end
        end
      end

      ST_BYTE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
          if (pack_cnt == VB_W'(8)) begin
            out_valid_nxt  = 1'b1;
            out_word_nxt   = pack_v;
            out_vb_nxt     = VB_W'(8);
            out_end_nxt    = is_end_r;
            out_last_nxt   = 1'b1;
            pend_bytes_nxt = '0;
            pend_cnt_nxt   = '0;
          end else if (is_end_r) begin
            out_valid_nxt  = 1'b1;
            out_word_nxt   = pack_v << {pack_sh, 3'b000};
            out_vb_nxt     = pack_cnt;
            out_end_nxt    = 1'b1;
            out_last_nxt   = 1'b1;
            pend_bytes_nxt = '0;
            pend_cnt_nxt   = '0;
          end else begin
            // Hold the byte until the word fills
            pend_bytes_nxt = pack_v[55:0];
            pend_cnt_nxt   = pack_cnt[2:0];
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= '0;
      first_uni_r  <= UNI_W'(1);
      state_r      <= ST_IDLE;
      chan_pos_r   <= '0;
      seq_r        <= '0;
      hdr_idx_r    <= '0;
      pend_cnt_r   <= '0;
      pend_bytes_r <= '0;
      is_end_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_CHANNEL_COUNT)) begin
        chan_count_r <= cfg_data[CNT_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_FIRST_UNIVERSE)) begin
        first_uni_r <= cfg_data[UNI_W-1:0];
      end
      state_r      <= state_nxt;
      chan_pos_r   <= chan_pos_nxt;
      seq_r        <= seq_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      pend_bytes_r <= pend_bytes_nxt;
      is_end_r     <= is_end_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    ctx_r      <= ctx_nxt;
    out_word_r <= out_word_nxt;
    out_vb_r   <= out_vb_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.packet_word = out_word_r;
  assign out_chan.valid_bytes = out_vb_r;
  assign out_chan.packet_end  = out_end_r;
  assign out_chan.run_last    = out_last_r;

  // A packet only ends in the pack step, whose result beats always close the run
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.packet_end |-> out_chan.run_last)
    else $error("packet_end beat without run_last");

  // Byte count of a beat stays within one word
  a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.valid_bytes != '0) &&
                       (out_chan.valid_bytes <= VB_W'(8)))
    else $error("valid_bytes out of range");

  // Bytes past the valid count are zero
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.valid_bytes < VB_W'(8)) |->
      ((out_chan.packet_word << {out_chan.valid_bytes, 3'b000}) == '0))
    else $error("packet_word has bytes past valid_bytes");

  // Leaving the header hands six tail bytes to the packer
  a_hdr_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HDR) && slot_free &&
    (hdr_idx_r == HDR_IDX_W'(HDR_FULL_WORDS - 1)) |=>
      (state_r == ST_BYTE) && (pend_cnt_r == 3'd6))
    else $error("header hand-off to packer broken");

endmodule
